// ===== hdl/sorted_interval_priority_queue_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SORTED_INTERVAL_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_INTERVAL_PRIORITY_QUEUE_ASSERT_SVH

// Check c on the cycle after a.
`define SIPQ_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("sipq check failed");

// Check c in the same cycle as a.
`define SIPQ_ASSERT_NOW(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("sipq check failed");

`endif

// ===== hdl/sipq_pkg.sv =====
`default_nettype none
package sipq_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_POP    = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic                   ins;
    logic                   pop;
    logic [VALUE_WIDTH-1:0] key;
    logic [VALUE_WIDTH-1:0] val;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/sorted_interval_priority_queue.sv =====
`default_nettype none
// Sorted interval priority queue: a row of cells holding (start, end) pairs,
// cell 0 holding the smallest start.
// Command channel: a word is taken at a rising edge with start high and busy
// low. cmd_i = 0 inserts (start_key_i, end_value_i) in front of the first
// entry whose start is greater than or equal to the new start; cmd_i = 1
// pops the entry in cell 0.
// Result channel: done_o is high for exactly one cycle, the cycle after the
// command word is taken, with status_o, popped_start_o, popped_end_o and
// entry_count_o. The receiver cannot stall; each result word is shown once.
// One command is taken every cycle: every cell compares its key with the
// new key in parallel and shifts left or right in the same edge, so busy
// stays low.
// An insert into a full queue reports status full and changes nothing; a pop
// of an empty queue reports status empty and changes nothing.
// Reset clears the entry count and the result strobe; cell contents are not
// cleared and are never read before they are written.
module sorted_interval_priority_queue (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start,
  output logic                                     busy,
  input  logic                                     cmd_i,
  input  logic signed [sipq_pkg::VALUE_WIDTH-1:0]  start_key_i,
  input  logic signed [sipq_pkg::VALUE_WIDTH-1:0]  end_value_i,
  output logic                                     done_o,
  output logic [1:0]                               status_o,
  output logic signed [sipq_pkg::VALUE_WIDTH-1:0]  popped_start_o,
  output logic signed [sipq_pkg::VALUE_WIDTH-1:0]  popped_end_o,
  output logic [sipq_pkg::CNT_W-1:0]               entry_count_o
);

  localparam int N = sipq_pkg::CAPACITY;
  localparam int W = sipq_pkg::VALUE_WIDTH;

  logic                       accept;
  logic                       full, empty;
  sipq_pkg::cell_ctrl_t       ctrl;
  logic [N-1:0]               keep;
  logic [W-1:0]               key   [N];
  logic [W-1:0]               val   [N];

  logic [sipq_pkg::CNT_W-1:0] count_q, count_d;
  logic                       done_q;
  sipq_pkg::status_e          status_q, status_d;
  logic [W-1:0]               pstart_q, pstart_d;
  logic [W-1:0]               pend_q, pend_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == sipq_pkg::CNT_W'(N));
  assign empty  = (count_q == '0);

  always_comb begin
    ctrl.ins = 1'b0;
    ctrl.pop = 1'b0;
    ctrl.key = start_key_i;
    ctrl.val = end_value_i;
    count_d  = count_q;
    status_d = sipq_pkg::ST_OK;
    pstart_d = '0;
    pend_d   = '0;
    if (accept) begin
      unique case (sipq_pkg::cmd_e'(cmd_i))
        sipq_pkg::CMD_INSERT: begin
          if (full) begin
            status_d = sipq_pkg::ST_FULL;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + 1'b1;
          end
        end
        sipq_pkg::CMD_POP: begin
          if (empty) begin
            status_d = sipq_pkg::ST_EMPTY;
          end else begin
            ctrl.pop = 1'b1;
            pstart_d = key[0];
            pend_d   = val[0];
            count_d  = count_q - 1'b1;
          end
        end
        default: status_d = sipq_pkg::ST_OK;
      endcase
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic         valid;
    logic         left_keep;
    logic [W-1:0] left_key, left_val, right_key, right_val;

    assign valid = (sipq_pkg::CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_keep = 1'b1;
      assign left_key  = '0;
      assign left_val  = '0;
    end else begin : g_mid
      assign left_keep = keep[i-1];
      assign left_key  = key[i-1];
      assign left_val  = val[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right_key = '0;
      assign right_val = '0;
    end else begin : g_inner
      assign right_key = key[i+1];
      assign right_val = val[i+1];
    end

    sipq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (valid),
      .left_keep_i (left_keep),
      .left_key_i  (left_key),
      .left_val_i  (left_val),
      .right_key_i (right_key),
      .right_val_i (right_val),
      .key_o       (key[i]),
      .val_o       (val[i]),
      .keep_o      (keep[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    pstart_q <= pstart_d;
    pend_q   <= pend_d;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign popped_start_o = pstart_q;
  assign popped_end_o   = pend_q;
  assign entry_count_o  = count_q;

endmodule
`default_nettype wire

// ===== hdl/sipq_cell.sv =====
`default_nettype none
module sipq_cell (
  input  logic                                clk_i,
  input  sipq_pkg::cell_ctrl_t                ctrl_i,
  input  logic                                valid_i,
  input  logic                                left_keep_i,
  input  logic [sipq_pkg::VALUE_WIDTH-1:0]    left_key_i,
  input  logic [sipq_pkg::VALUE_WIDTH-1:0]    left_val_i,
  input  logic [sipq_pkg::VALUE_WIDTH-1:0]    right_key_i,
  input  logic [sipq_pkg::VALUE_WIDTH-1:0]    right_val_i,
  output logic [sipq_pkg::VALUE_WIDTH-1:0]    key_o,
  output logic [sipq_pkg::VALUE_WIDTH-1:0]    val_o,
  output logic                                keep_o
);

  logic [sipq_pkg::VALUE_WIDTH-1:0] key_q, key_d;
  logic [sipq_pkg::VALUE_WIDTH-1:0] val_q, val_d;

  assign keep_o = valid_i && ($signed(key_q) < $signed(ctrl_i.key));
  assign key_o  = key_q;
  assign val_o  = val_q;

  always_comb begin
    key_d = key_q;
    val_d = val_q;
    if (ctrl_i.ins && !keep_o) begin
      if (left_keep_i) begin
        key_d = ctrl_i.key;
        val_d = ctrl_i.val;
      end else begin
        key_d = left_key_i;
        val_d = left_val_i;
      end
    end else if (ctrl_i.pop) begin
      key_d = right_key_i;
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

endmodule
`default_nettype wire

// ===== hdl/sipq_checker.sv =====
`default_nettype none
`include "sorted_interval_priority_queue_assert.svh"
module sipq_checker (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start,
  input  logic                                     busy,
  input  logic                                     cmd_i,
  input  logic                                     done_o,
  input  logic [1:0]                               status_o,
  input  logic signed [sipq_pkg::VALUE_WIDTH-1:0]  popped_start_o,
  input  logic signed [sipq_pkg::VALUE_WIDTH-1:0]  popped_end_o,
  input  logic [sipq_pkg::CNT_W-1:0]               entry_count_o
);

  logic accept;
  assign accept = start && !busy;

  `SIPQ_ASSERT_NEXT(a_word_strobed, clk_i, rst_ni, accept, done_o)
  `SIPQ_ASSERT_NEXT(a_no_stray_strobe, clk_i, rst_ni, !accept, !done_o)
  `SIPQ_ASSERT_NOW(a_empty_count, clk_i, rst_ni,
    done_o && status_o == sipq_pkg::ST_EMPTY, entry_count_o == '0)
  `SIPQ_ASSERT_NOW(a_full_count, clk_i, rst_ni,
    done_o && status_o == sipq_pkg::ST_FULL,
    entry_count_o == sipq_pkg::CNT_W'(sipq_pkg::CAPACITY))
  `SIPQ_ASSERT_NOW(a_insert_no_data, clk_i, rst_ni,
    done_o && $past(cmd_i) == sipq_pkg::CMD_INSERT,
    popped_start_o == '0 && popped_end_o == '0)

endmodule

bind sorted_interval_priority_queue sipq_checker u_sipq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .cmd_i          (cmd_i),
  .done_o         (done_o),
  .status_o       (status_o),
  .popped_start_o (popped_start_o),
  .popped_end_o   (popped_end_o),
  .entry_count_o  (entry_count_o)
);
`default_nettype wire
